/* rtl/core/wcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types, codes and slot tables of the weather channel statistics core.
// ----------------------------------------------------------------------------
package wcs_pkg;

  localparam int NUM_SLOTS = 10;
  localparam int SLOT_BITS = 4;
  localparam int NUM_QTY   = 6;

  localparam logic [SLOT_BITS-1:0] SLOT_WIND_DIR = 4'd6;
  localparam logic [SLOT_BITS-1:0] SLOT_GUST_DIR = 4'd7;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    QTY_PRESSURE = 3'd0,
    QTY_TEMP     = 3'd1,
    QTY_HUMIDITY = 3'd2,
    QTY_DEWPOINT = 3'd3,
    QTY_WIND_DIR = 3'd4,
    QTY_WIND_SPD = 3'd5
  } qty_t;

  typedef enum logic [2:0] {
    OP_MEAN = 3'd0,
    OP_MAX  = 3'd1,
    OP_MIN  = 3'd2,
    OP_GDIR = 3'd3,
    OP_GSPD = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture_add;
    logic capture_read;
    logic clear;
    logic upd_step;
    logic rd_load;
    logic div_step;
    logic out_load;
  } wcs_cmd_t;

  typedef struct packed {
    logic upd_last;
    logic need_div;
    logic div_last;
    logic out_busy;
  } wcs_status_t;

  function automatic op_t slot_op(input logic [SLOT_BITS-1:0] s);
    op_t op;
    unique case (s)
      4'd2:    op = OP_MAX;
      4'd3:    op = OP_MIN;
      4'd7:    op = OP_GDIR;
      4'd9:    op = OP_GSPD;
      default: op = OP_MEAN;
    endcase
    return op;
  endfunction

  function automatic logic [SLOT_BITS-1:0] first_slot(input logic [2:0] q);
    logic [SLOT_BITS-1:0] s;
    unique case (q)
      QTY_PRESSURE: s = 4'd0;
      QTY_TEMP:     s = 4'd1;
      QTY_HUMIDITY: s = 4'd4;
      QTY_DEWPOINT: s = 4'd5;
      QTY_WIND_DIR: s = 4'd6;
      QTY_WIND_SPD: s = 4'd8;
      default:      s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [SLOT_BITS-1:0] last_slot(input logic [2:0] q);
    logic [SLOT_BITS-1:0] s;
    unique case (q)
      QTY_PRESSURE: s = 4'd0;
      QTY_TEMP:     s = 4'd3;
      QTY_HUMIDITY: s = 4'd4;
      QTY_DEWPOINT: s = 4'd5;
      QTY_WIND_DIR: s = 4'd6;
      QTY_WIND_SPD: s = 4'd9;
      default:      s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/wcs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_if
// Valid/ready channels of the statistics core: sample/command and result.
// ----------------------------------------------------------------------------
interface wcs_in_if #(parameter int VALUE_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic [2:0]                   quantity;
  logic signed [VALUE_BITS-1:0] sample_value;
  logic [3:0]                   read_slot;

  modport source (output valid, func, quantity, sample_value, read_slot, input ready);
  modport sink   (input valid, func, quantity, sample_value, read_slot, output ready);
endinterface

interface wcs_out_if #(parameter int VALUE_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] stat_value;
  logic                         stat_valid;

  modport source (output valid, stat_value, stat_valid, input ready);
  modport sink   (input valid, stat_value, stat_valid, output ready);
endinterface

/* rtl/core/wcs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_ctrl
// Sequencer: accepts a beat, walks the slots of a sample, runs the divider.
// ----------------------------------------------------------------------------
module wcs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_func,
  input  logic [2:0]           in_quantity,
  output logic                 in_ready,
  input  wcs_pkg::wcs_status_t status,
  output wcs_pkg::wcs_cmd_t    cmd
);
  import wcs_pkg::*;

  state_t state_r, state_nxt;
  logic   take;
  logic   qty_ok;

  assign in_ready = (state_r == ST_IDLE);
  assign take     = in_valid && in_ready;
  assign qty_ok   = (in_quantity < 3'(NUM_QTY));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take && in_func == FUNC_ADD && qty_ok) begin
          state_nxt = ST_UPDATE;
        end else if (take && in_func == FUNC_READ) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_UPDATE: begin
        if (status.upd_last) state_nxt = ST_IDLE;
      end
      ST_LOAD: begin
        state_nxt = status.need_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (status.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture_add  = take && in_func == FUNC_ADD;
        cmd.capture_read = take && in_func == FUNC_READ;
        cmd.clear        = take && in_func == FUNC_CLEAR;
      end
      ST_UPDATE: cmd.upd_step = 1'b1;
      ST_LOAD:   cmd.rd_load  = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_DONE:   cmd.out_load = !status.out_busy;
    endcase
  end

endmodule

/* rtl/core/wcs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_datapath
// Slot accumulators and counts, slot update unit, bit-serial mean divider
// and result register.
// ----------------------------------------------------------------------------
module wcs_datapath #(
  parameter int COUNT_BITS = 8,
  parameter int VALUE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [2:0]                   in_quantity,
  input  logic signed [VALUE_BITS-1:0] in_sample_value,
  input  logic [3:0]                   in_read_slot,
  input  wcs_pkg::wcs_cmd_t            cmd,
  output wcs_pkg::wcs_status_t         status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] out_stat_value,
  output logic                         out_stat_valid
);
  import wcs_pkg::*;

  localparam int ACC_BITS = VALUE_BITS + COUNT_BITS;
  localparam int BC_BITS  = $clog2(ACC_BITS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // slot state
  logic signed [ACC_BITS-1:0]   acc_r [NUM_SLOTS];
  logic [COUNT_BITS-1:0]        cnt_r [NUM_SLOTS];
  logic signed [VALUE_BITS-1:0] last_dir_r;

  // captured beat
  logic [SLOT_BITS-1:0]         idx_r;
  logic [2:0]                   qty_r;
  logic signed [VALUE_BITS-1:0] sample_r;

  // divider and result
  logic [ACC_BITS-1:0]          dvd_r;
  logic [COUNT_BITS-1:0]        rem_r;
  logic [COUNT_BITS-1:0]        dvs_r;
  logic [BC_BITS-1:0]           bit_cnt_r;
  logic                         neg_r;
  logic                         mean_r;
  logic                         hit_r;
  logic signed [VALUE_BITS-1:0] res_r;
  logic                         out_valid_r;
  logic signed [VALUE_BITS-1:0] out_value_r;
  logic                         out_hit_r;

  logic                         slot_ok;
  logic [SLOT_BITS-1:0]         rd_idx;
  op_t                          cur_op;
  logic signed [ACC_BITS-1:0]   acc_cur;
  logic [COUNT_BITS-1:0]        cnt_cur;
  logic signed [ACC_BITS-1:0]   v_ext;
  logic signed [ACC_BITS-1:0]   dir_ext;
  logic                         first;
  logic                         sat;
  logic                         acc_we;
  logic signed [ACC_BITS-1:0]   acc_val;
  logic                         bump;
  logic                         gust_we;
  logic                         rd_hit;
  logic                         rd_mean;
  logic [COUNT_BITS:0]          rem_sh;
  logic [COUNT_BITS:0]          rem_diff;
  logic                         q_bit;
  logic [ACC_BITS-1:0]          quot_s;

  assign slot_ok = (idx_r < SLOT_BITS'(NUM_SLOTS));
  assign rd_idx  = slot_ok ? idx_r : '0;
  assign cur_op  = slot_op(rd_idx);
  assign acc_cur = acc_r[rd_idx];
  assign cnt_cur = cnt_r[rd_idx];
  assign v_ext   = {{COUNT_BITS{sample_r[VALUE_BITS-1]}}, sample_r};
  assign dir_ext = {{COUNT_BITS{last_dir_r[VALUE_BITS-1]}}, last_dir_r};
  assign first   = (cnt_cur == '0);
  assign sat     = (cnt_cur == CNT_MAX);

  // slot update
  always_comb begin
    acc_we  = 1'b0;
    acc_val = v_ext;
    bump    = 1'b0;
    gust_we = 1'b0;
    unique case (cur_op)
      OP_MEAN: begin
        acc_we  = !sat;
        acc_val = first ? v_ext : acc_cur + v_ext;
        bump    = !sat;
      end
      OP_MAX: begin
        acc_we = first || (v_ext > acc_cur);
        bump   = !sat;
      end
      OP_MIN: begin
        acc_we = first || (v_ext < acc_cur);
        bump   = !sat;
      end
      OP_GSPD: begin
        acc_we  = first || (v_ext > acc_cur);
        gust_we = acc_we;
        bump    = !sat;
      end
      OP_GDIR: begin
        acc_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_step) begin
      if (acc_we)  acc_r[rd_idx]        <= acc_val;
      if (gust_we) acc_r[SLOT_GUST_DIR] <= dir_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) cnt_r[i] <= '0;
      last_dir_r <= '0;
    end else if (cmd.clear) begin
      for (int i = 0; i < NUM_SLOTS; i++) cnt_r[i] <= '0;
    end else if (cmd.upd_step) begin
      if (bump)    cnt_r[rd_idx]        <= cnt_cur + 1'b1;
      if (gust_we) cnt_r[SLOT_GUST_DIR] <= COUNT_BITS'(1);
      if (rd_idx == SLOT_WIND_DIR) last_dir_r <= sample_r;
    end
  end

  // beat capture and slot walk
  always_ff @(posedge clk) begin
    if (cmd.capture_add) begin
      idx_r    <= first_slot(in_quantity);
      qty_r    <= in_quantity;
      sample_r <= in_sample_value;
    end else if (cmd.capture_read) begin
      idx_r <= in_read_slot;
    end else if (cmd.upd_step) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // read and restoring divider
  assign rd_hit   = slot_ok && !first;
  assign rd_mean  = rd_hit && (cur_op == OP_MEAN);
  assign rem_sh   = {rem_r, dvd_r[ACC_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign q_bit    = (rem_sh >= {1'b0, dvs_r});
  assign quot_s   = neg_r ? (~dvd_r + 1'b1) : dvd_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_load) begin
      neg_r     <= acc_cur[ACC_BITS-1];
      dvd_r     <= acc_cur[ACC_BITS-1] ? (~acc_cur + 1'b1) : acc_cur;
      rem_r     <= '0;
      dvs_r     <= cnt_cur;
      bit_cnt_r <= '0;
      mean_r    <= rd_mean;
      hit_r     <= rd_hit;
      res_r     <= (rd_hit && !rd_mean) ? acc_cur[VALUE_BITS-1:0] : '0;
    end else if (cmd.div_step) begin
      rem_r     <= q_bit ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
      dvd_r     <= {dvd_r[ACC_BITS-2:0], q_bit};
      bit_cnt_r <= bit_cnt_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= mean_r ? quot_s[VALUE_BITS-1:0] : res_r;
      out_hit_r   <= hit_r;
    end
  end

  assign status.upd_last = (idx_r == last_slot(qty_r));
  assign status.need_div = rd_mean;
  assign status.div_last = (bit_cnt_r == BC_BITS'(ACC_BITS - 1));
  assign status.out_busy = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_stat_value = out_value_r;
  assign out_stat_valid = out_hit_r;

endmodule

/* rtl/core/weather_channel_statistics_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weather_channel_statistics_core
// Ten weather statistic slots (means, extremes, gust) fed by samples and
// read back as mean or extreme with a valid flag.
// ----------------------------------------------------------------------------
//  channel   role    beat contents
//  in_bus    sink    func, quantity, sample_value, read_slot
//  out_bus   source  stat_value, stat_valid (one beat per read)
//
//  add: accepted, then one update step per slot tied to the quantity (1 to 3);
//  read of a mean: one-bit-per-cycle restoring divider; any other read
//  (extreme, gust direction, empty or invalid slot) skips it; clear: empties
//  all slot counts; reset clears counts, last wind direction and control; the
//  result register lets adds and clears run while a read result is stalled;
//  a second read waits for out_bus.ready; its result loads in that same cycle
// ----------------------------------------------------------------------------
module weather_channel_statistics_core #(
  parameter int COUNT_BITS = 8,
  parameter int VALUE_BITS = 24
) (
  input logic        clk,
  input logic        rst_n,
  wcs_in_if.sink     in_bus,
  wcs_out_if.source  out_bus
);
  import wcs_pkg::*;

  wcs_cmd_t    cmd;
  wcs_status_t status;

  wcs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_bus.valid),
    .in_func     (in_bus.func),
    .in_quantity (in_bus.quantity),
    .in_ready    (in_bus.ready),
    .status      (status),
    .cmd         (cmd)
  );

  wcs_datapath #(
    .COUNT_BITS (COUNT_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_quantity     (in_bus.quantity),
    .in_sample_value (in_bus.sample_value),
    .in_read_slot    (in_bus.read_slot),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .out_stat_value  (out_bus.stat_value),
    .out_stat_valid  (out_bus.stat_valid)
  );

endmodule

/* rtl/core/wcs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_checker
// Port-level checks of the statistics core, bound to the top level.
// ----------------------------------------------------------------------------
module wcs_checker #(
  parameter int VALUE_BITS = 24
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [1:0]            in_func,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VALUE_BITS-1:0] out_stat_value,
  input logic                  out_stat_valid
);
  import wcs_pkg::*;

  // stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a read keeps the input not ready right after it is accepted
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_READ |=> !in_ready)
    else $error("input accepted right after a read");

  // adds, clears and idle beats never make a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_ready |=> !out_valid)
    else $error("result beat without a read");

  // an invalid slot reads as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stat_valid |-> out_stat_value == '0)
    else $error("invalid result is not zero");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind weather_channel_statistics_core wcs_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_wcs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .in_func        (in_bus.func),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_stat_value (out_bus.stat_value),
  .out_stat_valid (out_bus.stat_valid)
);
